>>> hdl/joystick_axis_conditioner_core_macros.svh
// ----------------------------------------------------------------------------
// Joystick axis conditioner assertion macros
// Shared property forms for the conditioner core, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_AXIS_CONDITIONER_CORE_MACROS_SVH
`define JOYSTICK_AXIS_CONDITIONER_CORE_MACROS_SVH

// same-cycle implication
`define JAC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/jac_pkg.sv
// ----------------------------------------------------------------------------
// Joystick axis conditioner package
// Field widths, register indexes and the result layout of the conditioner.
// ----------------------------------------------------------------------------
package jac_pkg;

    localparam int FIELD_W    = 12;
    localparam int DZ_W       = 10;
    localparam int ALPHA_W    = 9;
    localparam int FRAC_BITS  = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;
    localparam int IN_DATA_W  = 2 * FIELD_W;
    localparam int OUT_DATA_W = 4 * FIELD_W;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_X    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_X    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_Y    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_Y    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_DEADZONE = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA    = 3'd7;

    typedef struct packed {
        logic [FIELD_W-1:0] echo_y;
        logic [FIELD_W-1:0] echo_x;
        logic [FIELD_W-1:0] out_y;
        logic [FIELD_W-1:0] out_x;
    } result_t;

endpackage

>>> hdl/joystick_axis_conditioner_core.sv
// ----------------------------------------------------------------------------
// Joystick axis conditioner core
// Smooths an X/Y ADC sample pair, clamps it to calibration and maps it
// piecewise linearly around the calibrated center with a deadzone.
// ----------------------------------------------------------------------------
// One sample pair is taken when the core is idle; X is worked first, then Y,
// on one shared multiplier and one restoring divider that retires one
// quotient bit per cycle. Each axis runs the filter update (S_MUL0, S_MUL1),
// S_CLAMP and S_CHECK; an axis inside the deadzone (or with an empty or
// inverted span) then maps to OUT_CENTER, any other goes on through S_PROD,
// S_DIV, which yields NUM_W quotient bits, and S_MAP, where NUM_W = 12 + bits
// of the larger output half-range (24 at the default parameters). The first
// pair after reset loads the filter directly. The result sits in an output
// register, so the next pair is taken while it waits to be read; the hand-off
// stalls only while an earlier result is still unread.
`include "joystick_axis_conditioner_core_macros.svh"

module joystick_axis_conditioner_core
    import jac_pkg::*;
#(
    parameter int ADC_BITS   = 12,
    parameter int OUT_CENTER = 2048,
    parameter int OUT_MAX    = 4095
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // raw_x, raw_y
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // out_x, out_y, echo_x, echo_y
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int ACC_W    = ADC_BITS + FRAC_BITS;
    localparam int SM_W     = ADC_BITS + 1;
    localparam int CMP_W    = (SM_W > FIELD_W) ? SM_W : FIELD_W;
    localparam int TMP_W    = ACC_W + ALPHA_W;
    localparam int K_LO     = OUT_CENTER;
    localparam int K_HI     = OUT_MAX - OUT_CENTER;
    localparam logic K_HI_NEG = (K_HI < 0);
    localparam int K_HI_ABS = (K_HI < 0) ? -K_HI : K_HI;
    localparam int K_MAX    = (K_LO > K_HI_ABS) ? K_LO : K_HI_ABS;
    localparam int KW       = $clog2(K_MAX + 1);
    localparam int MB_W     = (KW > ALPHA_W) ? KW : ALPHA_W;
    localparam int MA_W     = ACC_W;
    localparam int P_W      = MA_W + MB_W;
    localparam int NUM_W    = FIELD_W + KW;
    localparam int CNT_W    = $clog2(NUM_W + 1);
    localparam int RW       = ((NUM_W > 17) ? NUM_W : 17) + 2;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL0  = 4'd1;
    localparam logic [3:0] S_MUL1  = 4'd2;
    localparam logic [3:0] S_CLAMP = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_PROD  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_MAP   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    // configuration
    logic [FIELD_W-1:0] center_x_reg, center_y_reg;
    logic [FIELD_W-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic [DZ_W-1:0]    deadzone_reg;
    logic [ALPHA_W-1:0] alpha_reg;

    // control
    logic [3:0]       state_reg, state_next;
    logic             axis_reg, axis_next;
    logic             load_reg, load_next;
    logic             filter_ready_reg, filter_ready_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic [ACC_W-1:0] acc_x_reg, acc_x_next, acc_y_reg, acc_y_next;

    // datapath
    logic [FIELD_W-1:0] raw_x_reg, raw_x_next, raw_y_reg, raw_y_next;
    logic [TMP_W-1:0]   tmp_reg, tmp_next;
    logic [FIELD_W-1:0] v_reg, v_next;
    logic [FIELD_W-1:0] absd_reg, absd_next;
    logic [FIELD_W-1:0] span_reg, span_next;
    logic               side_lo_reg, side_lo_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [FIELD_W-1:0] rem_reg, rem_next;
    logic [FIELD_W-1:0] res_x_reg, res_x_next, res_y_reg, res_y_next;
    result_t            m_data_reg, m_data_next;

    logic               in_fire;
    logic [ACC_W-1:0]   acc_cur;
    logic [FIELD_W-1:0] raw_cur, ctr_cur, min_cur, max_cur;
    logic [ADC_BITS-1:0] raw_adc;
    logic [ALPHA_W-1:0] alpha_sat;
    logic [MA_W-1:0]    mul_a;
    logic [MB_W-1:0]    mul_b;
    logic [P_W-1:0]     mul_p;
    logic [TMP_W-1:0]   tmp_rnd;
    logic [ACC_W-1:0]   acc_upd;
    logic [ACC_W:0]     sm_sum;
    logic [CMP_W-1:0]   smooth_c, min_c, max_c;
    logic [FIELD_W-1:0] v_clamp;
    logic [FIELD_W:0]   d, span_lo, span_hi, span_sel;
    logic [FIELD_W-1:0] absd;
    logic               v_below, span_bad, in_dz;
    logic [FIELD_W:0]   trial;
    logic               q_bit;
    logic signed [RW-1:0] q_s, center_s, res_raw, lo_s, hi_s, res_cl;
    logic               axis_done;
    logic [FIELD_W-1:0] axis_val;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign acc_cur   = axis_reg ? acc_y_reg : acc_x_reg;
    assign raw_cur   = axis_reg ? raw_y_reg : raw_x_reg;
    assign ctr_cur   = axis_reg ? center_y_reg : center_x_reg;
    assign min_cur   = axis_reg ? min_y_reg : min_x_reg;
    assign max_cur   = axis_reg ? max_y_reg : max_x_reg;
    assign raw_adc   = ADC_BITS'(raw_cur);
    assign alpha_sat = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL0:
            begin
                mul_a = acc_cur;
                mul_b = MB_W'(ALPHA_ONE - alpha_sat);
            end
            S_MUL1:
            begin
                mul_a = MA_W'(raw_adc);
                mul_b = MB_W'(alpha_sat);
            end
            S_PROD:
            begin
                mul_a = MA_W'(absd_reg);
                mul_b = side_lo_reg ? MB_W'(K_LO) : MB_W'(K_HI_ABS);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = P_W'(mul_a) * P_W'(mul_b);
    assign tmp_rnd = (tmp_reg + TMP_W'(128)) >> FRAC_BITS;
    assign acc_upd = ACC_W'(mul_p + P_W'(tmp_rnd));

    assign sm_sum   = {1'b0, acc_cur} + (ACC_W+1)'(128);
    assign smooth_c = CMP_W'(sm_sum[ACC_W:FRAC_BITS]);
    assign min_c    = CMP_W'(min_cur);
    assign max_c    = CMP_W'(max_cur);
    assign v_clamp  = (smooth_c < min_c) ? min_cur :
                      (smooth_c > max_c) ? max_cur : FIELD_W'(smooth_c);

    assign d        = {1'b0, v_reg} - {1'b0, ctr_cur};
    assign v_below  = d[FIELD_W];
    assign absd     = v_below ? FIELD_W'(-d) : d[FIELD_W-1:0];
    assign in_dz    = (absd <= FIELD_W'(deadzone_reg));
    assign span_lo  = {1'b0, ctr_cur} - {1'b0, min_cur};
    assign span_hi  = {1'b0, max_cur} - {1'b0, ctr_cur};
    assign span_sel = v_below ? span_lo : span_hi;
    assign span_bad = span_sel[FIELD_W] || (span_sel == '0);

    assign trial = {rem_reg, num_reg[NUM_W-1]} - {1'b0, span_reg};
    assign q_bit = !trial[FIELD_W];

    assign q_s      = signed'(RW'(num_reg));
    assign center_s = signed'(RW'(OUT_CENTER));
    assign res_raw  = (side_lo_reg || K_HI_NEG) ? (center_s - q_s) : (center_s + q_s);
    assign lo_s     = side_lo_reg ? signed'(RW'(0)) : center_s;
    assign hi_s     = side_lo_reg ? center_s : signed'(RW'(OUT_MAX));
    assign res_cl   = (res_raw < lo_s) ? lo_s : (res_raw > hi_s) ? hi_s : res_raw;

    always_comb
    begin
        state_next        = state_reg;
        axis_next         = axis_reg;
        load_next         = load_reg;
        filter_ready_next = filter_ready_reg;
        cnt_next          = cnt_reg;
        m_valid_next      = m_valid_reg;
        acc_x_next        = acc_x_reg;
        acc_y_next        = acc_y_reg;
        raw_x_next        = raw_x_reg;
        raw_y_next        = raw_y_reg;
        tmp_next          = tmp_reg;
        v_next            = v_reg;
        absd_next         = absd_reg;
        span_next         = span_reg;
        side_lo_next      = side_lo_reg;
        num_next          = num_reg;
        rem_next          = rem_reg;
        res_x_next        = res_x_reg;
        res_y_next        = res_y_reg;
        m_data_next       = m_data_reg;
        axis_done         = 1'b0;
        axis_val          = FIELD_W'(OUT_CENTER);

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    raw_x_next = s_axis_tdata[FIELD_W-1:0];
                    raw_y_next = s_axis_tdata[2*FIELD_W-1:FIELD_W];
                    axis_next  = 1'b0;
                    load_next  = !filter_ready_reg;
                    if (!filter_ready_reg)
                    begin
                        acc_x_next = ACC_W'(ADC_BITS'(s_axis_tdata[FIELD_W-1:0]))
                                     << FRAC_BITS;
                        acc_y_next = ACC_W'(ADC_BITS'(s_axis_tdata[2*FIELD_W-1:FIELD_W]))
                                     << FRAC_BITS;
                        filter_ready_next = 1'b1;
                        state_next = S_CLAMP;
                    end
                    else
                    begin
                        state_next = S_MUL0;
                    end
                end
            end
            S_MUL0:
            begin
                tmp_next   = TMP_W'(mul_p);
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                if (axis_reg)
                begin
                    acc_y_next = acc_upd;
                end
                else
                begin
                    acc_x_next = acc_upd;
                end
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                v_next     = v_clamp;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                absd_next    = absd;
                span_next    = span_sel[FIELD_W-1:0];
                side_lo_next = v_below;
                if (in_dz || span_bad)
                begin
                    axis_done = 1'b1;
                end
                else
                begin
                    state_next = S_PROD;
                end
            end
            S_PROD:
            begin
                num_next   = NUM_W'(mul_p);
                rem_next   = '0;
                cnt_next   = CNT_W'(NUM_W);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = q_bit ? trial[FIELD_W-1:0]
                                 : {rem_reg[FIELD_W-2:0], num_reg[NUM_W-1]};
                num_next = {num_reg[NUM_W-2:0], q_bit};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                axis_done = 1'b1;
                axis_val  = res_cl[FIELD_W-1:0];
            end
            S_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_data_next.out_x  = res_x_reg;
                    m_data_next.out_y  = res_y_reg;
                    m_data_next.echo_x = raw_x_reg;
                    m_data_next.echo_y = raw_y_reg;
                    m_valid_next       = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (axis_done)
        begin
            if (axis_reg)
            begin
                res_y_next = axis_val;
                state_next = S_DONE;
            end
            else
            begin
                res_x_next = axis_val;
                axis_next  = 1'b1;
                state_next = load_reg ? S_CLAMP : S_MUL0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= 12'd2048;
            center_y_reg <= 12'd2048;
            min_x_reg    <= 12'd0;
            max_x_reg    <= 12'd4095;
            min_y_reg    <= 12'd0;
            max_y_reg    <= 12'd4095;
            deadzone_reg <= 10'd40;
            alpha_reg    <= 9'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_CENTER_X: center_x_reg <= cfg_wdata;
                REG_CENTER_Y: center_y_reg <= cfg_wdata;
                REG_MIN_X:    min_x_reg    <= cfg_wdata;
                REG_MAX_X:    max_x_reg    <= cfg_wdata;
                REG_MIN_Y:    min_y_reg    <= cfg_wdata;
                REG_MAX_Y:    max_y_reg    <= cfg_wdata;
                REG_DEADZONE: deadzone_reg <= cfg_wdata[DZ_W-1:0];
                REG_ALPHA:    alpha_reg    <= cfg_wdata[ALPHA_W-1:0];
                default:      alpha_reg    <= alpha_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            axis_reg         <= 1'b0;
            load_reg         <= 1'b0;
            filter_ready_reg <= 1'b0;
            cnt_reg          <= '0;
            m_valid_reg      <= 1'b0;
            acc_x_reg        <= '0;
            acc_y_reg        <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            axis_reg         <= axis_next;
            load_reg         <= load_next;
            filter_ready_reg <= filter_ready_next;
            cnt_reg          <= cnt_next;
            m_valid_reg      <= m_valid_next;
            acc_x_reg        <= acc_x_next;
            acc_y_reg        <= acc_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_x_reg   <= raw_x_next;
        raw_y_reg   <= raw_y_next;
        tmp_reg     <= tmp_next;
        v_reg       <= v_next;
        absd_reg    <= absd_next;
        span_reg    <= span_next;
        side_lo_reg <= side_lo_next;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        res_x_reg   <= res_x_next;
        res_y_reg   <= res_y_next;
        m_data_reg  <= m_data_next;
    end

    `JAC_ASSERT_NEXT(a_busy_after_accept, in_fire, state_reg != S_IDLE,
        "core still idle after taking a transaction")
    `JAC_ASSERT_SAME(a_div_count_live, state_reg == S_DIV, cnt_reg != '0,
        "divider running with an exhausted bit count")
    `JAC_ASSERT_SAME(a_div_rem_bound, state_reg == S_DIV, rem_reg < span_reg,
        "divider remainder not below the span")
    `JAC_ASSERT_NEXT(a_filter_sticky, filter_ready_reg, filter_ready_reg,
        "filter lost its loaded state")
    `JAC_ASSERT_NEXT(a_done_holds, (state_reg == S_DONE) && m_valid_reg && !m_axis_tready,
        state_reg == S_DONE, "result dropped over a pending transaction")

endmodule
